// File: rtl/core/dbt_pkg.sv
// Shared types and codes for the dirty block tracker.
// No dependencies; every other file refers to it by scoped names.

package dbt_pkg;

    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 3;
    localparam int BLK_W     = 6;

    localparam logic [2:0] ACT_NODE = 3'd0;
    localparam logic [2:0] ACT_SIZE = 3'd1;
    localparam logic [2:0] ACT_DATA = 3'd2;
    localparam logic [2:0] ACT_ALL  = 3'd3;
    localparam logic [2:0] ACT_SYNC = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_BIG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_BLKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_OFS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_MAX  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_END,
        S_SCAN,
        S_SYNC,
        S_EMIT,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic load_in;
        logic load_mul;
        logic load_sum;
        logic load_end;
        logic step;
    } rng_ctl_t;

endpackage

// File: rtl/core/dirty_block_tracker_unit.sv
// Dirty block tracker top level: holds the layout registers and joins the
// sequencer with the byte range unit. Depends on dbt_pkg, dbt_range, dbt_ctrl.
//
// Usage: an item on the input channel (in_valid/in_ready) is a mark or a sync
// request. Mark items return one result; a sync returns one result per dirty
// block below image_blocks, in ascending order, with last set on the final one,
// or a single status result when there is nothing to do or the image is too big.
// Layout registers are written through cfg_wr_en/cfg_index/cfg_data; the user
// must write them only while idle; the block itself does not enforce this.
// A node mark runs multiply, address sum and end compute, then one overlap
// compare per block in the shared compare unit; mark all starts at the end
// compute; a rejected mark stops after the multiply and an unknown action
// replies at once. A writing sync steps through the blocks up to the last
// dirty one; other syncs reply at once. in_ready is high only between items.
// The result sits in an output register: the next item is taken while it waits,
// and a sync scan holds on a dirty block until the receiver takes the previous
// result. Reset clears the bitmap, the dirty flag and the layout registers to
// their defaults; no clearing pass is needed.

module dirty_block_tracker_unit #(
    parameter int BLOCK_COUNT = 64,
    parameter int BLOCK_SIZE  = 512,
    parameter int MAX_NODES   = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      action,
    input  logic [9:0]                      node_index,
    input  logic [31:0]                     data_offset,
    input  logic [31:0]                     length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dbt_pkg::BLK_W-1:0]       block_index,
    output logic                            write_request,
    output logic [1:0]                      status,
    output logic                            last,
    input  logic                            cfg_wr_en,
    input  logic [dbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dbt_pkg::CFG_W-1:0]       cfg_data
);

    logic        persist_reg;
    logic [7:0]  img_blks_reg;
    logic [19:0] node_base_reg;
    logic [20:0] stride_reg;
    logic [19:0] data_ofs_reg;
    logic [19:0] size_ofs_reg;
    logic [20:0] file_max_reg;

    dbt_pkg::rng_ctl_t rng_ctl;
    logic              rng_bad;
    logic              rng_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persist_reg   <= 1'b0;
            img_blks_reg  <= 8'd1;
            node_base_reg <= 20'd4;
            stride_reg    <= 21'd1024;
            data_ofs_reg  <= 20'd0;
            size_ofs_reg  <= 20'd0;
            file_max_reg  <= 21'd512;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dbt_pkg::CFG_PERSIST:   persist_reg   <= cfg_data[0];
                dbt_pkg::CFG_IMG_BLKS:  img_blks_reg  <= cfg_data[7:0];
                dbt_pkg::CFG_NODE_BASE: node_base_reg <= cfg_data[19:0];
                dbt_pkg::CFG_STRIDE:    stride_reg    <= cfg_data;
                dbt_pkg::CFG_DATA_OFS:  data_ofs_reg  <= cfg_data[19:0];
                dbt_pkg::CFG_SIZE_OFS:  size_ofs_reg  <= cfg_data[19:0];
                dbt_pkg::CFG_FILE_MAX:  file_max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    dbt_range #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .MAX_NODES  (MAX_NODES)
    ) u_range (
        .clk               (clk),
        .ctl               (rng_ctl),
        .action            (action),
        .node_index        (node_index),
        .data_offset       (data_offset),
        .length            (length),
        .nodes_base        (node_base_reg),
        .node_stride       (stride_reg),
        .data_field_offset (data_ofs_reg),
        .size_field_offset (size_ofs_reg),
        .file_max_size     (file_max_reg),
        .bad               (rng_bad),
        .hit               (rng_hit)
    );

    dbt_ctrl #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .block_index       (block_index),
        .write_request     (write_request),
        .status            (status),
        .last              (last),
        .persistent_enable (persist_reg),
        .image_blocks      (img_blks_reg),
        .rng_ctl           (rng_ctl),
        .rng_bad           (rng_bad),
        .rng_hit           (rng_hit)
    );

endmodule

// File: rtl/core/dbt_range.sv
// Byte range unit: record address, clipped length and the per-block overlap compare.
// Depends on dbt_pkg; driven step by step from dbt_ctrl.

module dbt_range #(
    parameter int BLOCK_SIZE = 512,
    parameter int MAX_NODES  = 64
) (
    input  logic                clk,
    input  dbt_pkg::rng_ctl_t   ctl,
    input  logic [2:0]          action,
    input  logic [9:0]          node_index,
    input  logic [31:0]         data_offset,
    input  logic [31:0]         length,
    input  logic [19:0]         nodes_base,
    input  logic [20:0]         node_stride,
    input  logic [19:0]         data_field_offset,
    input  logic [19:0]         size_field_offset,
    input  logic [20:0]         file_max_size,
    output logic                bad,
    output logic                hit
);

    localparam logic [31:0] BS = 32'(BLOCK_SIZE);

    logic [2:0]  action_reg;
    logic [9:0]  node_reg;
    logic [31:0] doff_reg;
    logic [31:0] len_in_reg;
    logic [30:0] prod_reg;
    logic [31:0] addend_reg;
    logic [31:0] len_reg;
    logic [31:0] start_reg;
    logic [31:0] endm1_reg;
    logic        len_nz_reg;
    logic [31:0] base_reg;

    logic [30:0] prod_w;
    logic [31:0] room;
    logic [31:0] clip;
    logic [31:0] addend_w;
    logic [31:0] len_w;
    logic [31:0] base_nb;

    assign prod_w  = 31'(node_reg) * 31'(node_stride);
    assign room    = {11'b0, file_max_size} - doff_reg;
    assign clip    = (len_in_reg < room) ? len_in_reg : room;
    assign base_nb = base_reg + BS;

    assign bad = ({1'b0, node_reg} >= 11'(MAX_NODES))
              || ((action_reg == dbt_pkg::ACT_DATA)
                  && ((len_in_reg == 32'd0) || (doff_reg >= {11'b0, file_max_size})));

    assign hit = len_nz_reg && (start_reg < base_nb) && (base_reg <= endm1_reg);

    always_comb
    begin
        unique case (action_reg)
            dbt_pkg::ACT_SIZE:
            begin
                addend_w = {12'b0, size_field_offset};
                len_w    = 32'd4;
            end
            dbt_pkg::ACT_DATA:
            begin
                addend_w = {12'b0, data_field_offset} + doff_reg;
                len_w    = clip;
            end
            default:
            begin
                addend_w = 32'd0;
                len_w    = {11'b0, node_stride};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            action_reg <= action;
            node_reg   <= node_index;
            doff_reg   <= data_offset;
            len_in_reg <= length;
        end
        if (ctl.load_mul)
        begin
            prod_reg   <= prod_w;
            addend_reg <= addend_w;
            len_reg    <= len_w;
        end
        if (ctl.load_sum)
        begin
            start_reg <= {12'b0, nodes_base} + {1'b0, prod_reg} + addend_reg;
        end
        if (ctl.load_end)
        begin
            endm1_reg  <= start_reg + len_reg - 32'd1;
            len_nz_reg <= (len_reg != 32'd0);
            base_reg   <= 32'd0;
        end
        else if (ctl.step)
        begin
            base_reg <= base_nb;
        end
    end

endmodule

// File: rtl/core/dbt_ctrl.sv
// Sequencer, dirty bitmap and result register of the dirty block tracker.
// Depends on dbt_pkg; steers dbt_range through a dbt_pkg::rng_ctl_t bundle.

module dbt_ctrl #(
    parameter int BLOCK_COUNT = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  action,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dbt_pkg::BLK_W-1:0]   block_index,
    output logic                        write_request,
    output logic [1:0]                  status,
    output logic                        last,
    input  logic                        persistent_enable,
    input  logic [7:0]                  image_blocks,
    output dbt_pkg::rng_ctl_t           rng_ctl,
    input  logic                        rng_bad,
    input  logic                        rng_hit
);

    localparam logic [dbt_pkg::BLK_W-1:0] BLK_LAST = dbt_pkg::BLK_W'(BLOCK_COUNT - 1);

    dbt_pkg::state_t state_reg, state_next;

    logic [2:0]                 action_reg;
    logic [dbt_pkg::BLK_W-1:0]  blk_reg;
    logic [BLOCK_COUNT-1:0]     sel_reg;
    logic [BLOCK_COUNT-1:0]     dirty_reg;
    logic [BLOCK_COUNT-1:0]     pend_reg;
    logic                       any_reg;
    logic [1:0]                 status_reg;
    logic                       out_valid_reg;
    logic [dbt_pkg::BLK_W-1:0]  out_blk_reg;
    logic                       out_req_reg;
    logic [1:0]                 out_status_reg;
    logic                       out_last_reg;

    logic [BLOCK_COUNT-1:0]     below_mask;
    logic [BLOCK_COUNT-1:0]     pend_init;
    logic                       accept;
    logic                       out_free;
    logic                       in_image;
    logic                       scan_hit;
    logic                       emit_hit;
    logic                       emit_last;
    logic                       emit_go;
    logic                       reply_go;
    logic                       advance;
    logic                       sync_idle;
    logic                       sync_big;
    logic                       pend_none;
    logic [1:0]                 rep_status;

    for (genvar i = 0; i < BLOCK_COUNT; i++)
    begin : g_below
        assign below_mask[i] = (8'(i) < image_blocks);
    end

    assign pend_init = dirty_reg & below_mask;
    assign pend_none = ~|pend_init;
    assign sync_idle = !persistent_enable || !any_reg;
    assign sync_big  = ({1'b0, image_blocks} > 9'(BLOCK_COUNT));
    assign out_free  = !out_valid_reg || out_ready;
    assign in_image  = ({2'b0, blk_reg} < image_blocks);
    assign emit_hit  = |(pend_reg & sel_reg);
    assign emit_last = ~|(pend_reg & ~sel_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    priority case (action)
                        dbt_pkg::ACT_NODE, dbt_pkg::ACT_SIZE, dbt_pkg::ACT_DATA:
                            state_next = dbt_pkg::S_MUL;
                        dbt_pkg::ACT_ALL:  state_next = dbt_pkg::S_END;
                        dbt_pkg::ACT_SYNC: state_next = dbt_pkg::S_SYNC;
                        default:           state_next = dbt_pkg::S_REPLY;
                    endcase
                end
            end
            dbt_pkg::S_MUL:
                state_next = rng_bad ? dbt_pkg::S_REPLY : dbt_pkg::S_SUM;
            dbt_pkg::S_SUM:
                state_next = dbt_pkg::S_END;
            dbt_pkg::S_END:
                state_next = dbt_pkg::S_SCAN;
            dbt_pkg::S_SCAN:
                if (blk_reg == BLK_LAST)
                    state_next = dbt_pkg::S_REPLY;
            dbt_pkg::S_SYNC:
                state_next = (sync_idle || sync_big || pend_none) ? dbt_pkg::S_REPLY
                                                                  : dbt_pkg::S_EMIT;
            dbt_pkg::S_EMIT:
                if (emit_go && emit_last)
                    state_next = dbt_pkg::S_IDLE;
            dbt_pkg::S_REPLY:
                if (out_free)
                    state_next = dbt_pkg::S_IDLE;
            default:
                state_next = dbt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == dbt_pkg::S_IDLE);
        accept   = in_valid && in_ready;
        scan_hit = (action_reg == dbt_pkg::ACT_ALL) ? in_image : rng_hit;
        emit_go  = (state_reg == dbt_pkg::S_EMIT) && emit_hit && out_free;
        reply_go = (state_reg == dbt_pkg::S_REPLY) && out_free;
        advance  = (state_reg == dbt_pkg::S_SCAN)
                || ((state_reg == dbt_pkg::S_EMIT) && (!emit_hit || (out_free && !emit_last)));

        rng_ctl.load_in  = accept;
        rng_ctl.load_mul = (state_reg == dbt_pkg::S_MUL);
        rng_ctl.load_sum = (state_reg == dbt_pkg::S_SUM);
        rng_ctl.load_end = (state_reg == dbt_pkg::S_END);
        rng_ctl.step     = (state_reg == dbt_pkg::S_SCAN);

        unique case (state_reg)
            dbt_pkg::S_IDLE, dbt_pkg::S_MUL:
                rep_status = dbt_pkg::ST_BAD;
            dbt_pkg::S_SYNC:
                rep_status = (!sync_idle && sync_big) ? dbt_pkg::ST_BIG : dbt_pkg::ST_DONE;
            default:
                rep_status = dbt_pkg::ST_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbt_pkg::S_IDLE;
            dirty_reg     <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == dbt_pkg::S_SCAN) && scan_hit)
            begin
                dirty_reg <= dirty_reg | sel_reg;
                any_reg   <= 1'b1;
            end
            else if (emit_go)
            begin
                dirty_reg <= dirty_reg & ~sel_reg;
                if (emit_last)
                    any_reg <= 1'b0;
            end
            else if ((state_reg == dbt_pkg::S_SYNC) && !sync_idle && !sync_big && pend_none)
            begin
                any_reg <= 1'b0;
            end

            if (emit_go || reply_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            action_reg <= action;

        if ((state_reg == dbt_pkg::S_END) || (state_reg == dbt_pkg::S_SYNC))
        begin
            blk_reg <= '0;
            sel_reg <= BLOCK_COUNT'(1);
        end
        else if (advance)
        begin
            blk_reg <= blk_reg + 1'b1;
            sel_reg <= sel_reg << 1;
        end

        if (state_reg == dbt_pkg::S_SYNC)
            pend_reg <= pend_init;
        else if (emit_go)
            pend_reg <= pend_reg & ~sel_reg;

        if ((state_next == dbt_pkg::S_REPLY) && (state_reg != dbt_pkg::S_REPLY))
            status_reg <= rep_status;

        if (emit_go)
        begin
            out_blk_reg    <= blk_reg;
            out_req_reg    <= 1'b1;
            out_status_reg <= dbt_pkg::ST_DONE;
            out_last_reg   <= emit_last;
        end
        else if (reply_go)
        begin
            out_blk_reg    <= '0;
            out_req_reg    <= 1'b0;
            out_status_reg <= status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign block_index   = out_blk_reg;
    assign write_request = out_req_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;

endmodule

// File: tb/sv/dirty_block_tracker_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dirty_block_tracker_unit: queued mark/sync items, a bitmap
// predictor and an in-order result checker. Depends on dbt_pkg and the tracker RTL.

module dirty_block_tracker_unit_tb;

    localparam int BLOCK_COUNT = 64;
    localparam int BLOCK_SIZE = 512;
    localparam int MAX_NODES = 64;
    localparam logic [31:0] BLOCK_BYTES = 32'(BLOCK_SIZE);
    localparam int SETTLE_CYCLES = 100;
    localparam int RX_HOLD_CYCLES = 800;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0]  act;
        logic [9:0]  node;
        logic [31:0] doff;
        logic [31:0] nbytes;
    } req_t;

    typedef struct packed {
        logic [dbt_pkg::BLK_W-1:0] blk;
        logic                      wr;
        logic [1:0]                st;
        logic                      lst;
    } result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [2:0]                    action = dbt_pkg::ACT_NODE;
    logic [9:0]                    node_index = '0;
    logic [31:0]                   data_offset = '0;
    logic [31:0]                   length = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [dbt_pkg::BLK_W-1:0]     block_index;
    logic                          write_request;
    logic [1:0]                    status;
    logic                          last;
    logic                          cfg_wr_en = 1'b0;
    logic [dbt_pkg::CFG_IDX_W-1:0] cfg_index = dbt_pkg::CFG_PERSIST;
    logic [dbt_pkg::CFG_W-1:0]     cfg_data = '0;

    req_t    pending_q[$];
    result_t owed_q[$];

    logic [31:0] p_persist = 32'd0;
    logic [31:0] p_img = 32'd1;
    logic [31:0] p_base = 32'd4;
    logic [31:0] p_stride = 32'd1024;
    logic [31:0] p_data_ofs = 32'd0;
    logic [31:0] p_size_ofs = 32'd0;
    logic [31:0] p_fmax = 32'd512;
    logic [63:0] dirty_bits = '0;
    logic        any_marked = 1'b0;

    req_t    offered;
    result_t want;
    int      tx_wait = 0;
    int      rx_wait = 0;
    int      hold_grants = 0;
    int      holds_done = 0;
    bit      no_idle = 1'b0;
    int      idle_cycles = 0;
    int      error_count = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      writes_seen = 0;
    int      rejects_seen = 0;
    int      oversize_seen = 0;

    dirty_block_tracker_unit #(
        .BLOCK_COUNT(BLOCK_COUNT),
        .BLOCK_SIZE (BLOCK_SIZE),
        .MAX_NODES  (MAX_NODES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .node_index   (node_index),
        .data_offset  (data_offset),
        .length       (length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .block_index  (block_index),
        .write_request(write_request),
        .status       (status),
        .last         (last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic owe_result(input logic [dbt_pkg::BLK_W-1:0] blk, input logic wr,
                              input logic [1:0] st, input logic lst);
        result_t r;
        r.blk = blk;
        r.wr = wr;
        r.st = st;
        r.lst = lst;
        owed_q.push_back(r);
    endtask

    task automatic mark_bytes(input logic [31:0] start, input logic [31:0] nbytes);
        logic [31:0] lo;
        logic [31:0] hi;
        if (nbytes != 32'd0)
        begin
            lo = start / BLOCK_BYTES;
            hi = (start + nbytes - 32'd1) / BLOCK_BYTES;
            if (hi >= BLOCK_COUNT)
                hi = 32'(BLOCK_COUNT - 1);
            for (logic [31:0] b = lo; b <= hi; b++)
            begin
                dirty_bits[b] = 1'b1;
                any_marked = 1'b1;
            end
        end
    endtask

    task automatic predict_item(input req_t r);
        logic [31:0] rec;
        logic [31:0] span;
        int          top;
        rec = p_base + 32'(r.node) * p_stride;
        case (r.act)
            dbt_pkg::ACT_NODE, dbt_pkg::ACT_SIZE, dbt_pkg::ACT_DATA:
            begin
                if (r.node >= MAX_NODES)
                    owe_result('0, 1'b0, dbt_pkg::ST_BAD, 1'b1);
                else if (r.act == dbt_pkg::ACT_NODE)
                begin
                    mark_bytes(rec, p_stride);
                    owe_result('0, 1'b0, dbt_pkg::ST_DONE, 1'b1);
                end
                else if (r.act == dbt_pkg::ACT_SIZE)
                begin
                    mark_bytes(rec + p_size_ofs, 32'd4);
                    owe_result('0, 1'b0, dbt_pkg::ST_DONE, 1'b1);
                end
                else if (r.nbytes == 32'd0 || r.doff >= p_fmax)
                    owe_result('0, 1'b0, dbt_pkg::ST_BAD, 1'b1);
                else
                begin
                    span = p_fmax - r.doff;
                    if (r.nbytes < span)
                        span = r.nbytes;
                    mark_bytes(rec + p_data_ofs + r.doff, span);
                    owe_result('0, 1'b0, dbt_pkg::ST_DONE, 1'b1);
                end
            end
            dbt_pkg::ACT_ALL:
            begin
                for (int i = 0; i < p_img && i < BLOCK_COUNT; i++)
                begin
                    dirty_bits[i] = 1'b1;
                    any_marked = 1'b1;
                end
                owe_result('0, 1'b0, dbt_pkg::ST_DONE, 1'b1);
            end
            dbt_pkg::ACT_SYNC:
            begin
                if (p_persist[0] == 1'b0 || !any_marked)
                    owe_result('0, 1'b0, dbt_pkg::ST_DONE, 1'b1);
                else if (p_img > BLOCK_COUNT)
                    owe_result('0, 1'b0, dbt_pkg::ST_BIG, 1'b1);
                else
                begin
                    top = -1;
                    for (int i = 0; i < p_img; i++)
                        if (dirty_bits[i])
                            top = i;
                    for (int i = 0; i <= top; i++)
                    begin
                        if (dirty_bits[i])
                        begin
                            owe_result(dbt_pkg::BLK_W'(i), 1'b1, dbt_pkg::ST_DONE, i == top);
                            dirty_bits[i] = 1'b0;
                        end
                    end
                    any_marked = 1'b0;
                    if (top < 0)
                        owe_result('0, 1'b0, dbt_pkg::ST_DONE, 1'b1);
                end
            end
            default:
                owe_result('0, 1'b0, dbt_pkg::ST_BAD, 1'b1);
        endcase
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Sender: present queued items, idle at random between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_item(offered);
                items_sent++;
                tx_wait = pick_gap();
            end
            if (!in_valid || in_ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    offered = pending_q.pop_front();
                    in_valid <= 1'b1;
                    action <= offered.act;
                    node_index <= offered.node;
                    data_offset <= offered.doff;
                    length <= offered.nbytes;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result against the oldest owed one, stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (write_request)
                    writes_seen++;
                if (status == dbt_pkg::ST_BAD)
                    rejects_seen++;
                if (status == dbt_pkg::ST_BIG)
                    oversize_seen++;
                if (owed_q.size() == 0)
                    note_error($sformatf("Unexpected result: blk=%0d wr=%0b st=%0d last=%0b",
                                         block_index, write_request, status, last));
                else
                begin
                    want = owed_q.pop_front();
                    if (want.blk !== block_index || want.wr !== write_request ||
                        want.st !== status || want.lst !== last)
                        note_error($sformatf({"Mismatch on result %0d: expected blk=%0d ",
                                              "wr=%0b st=%0d last=%0b, got blk=%0d wr=%0b ",
                                              "st=%0d last=%0b"},
                                             results_seen, want.blk, want.wr, want.st,
                                             want.lst, block_index, write_request,
                                             status, last));
                end
                rx_wait = pick_gap();
            end
            if (hold_grants != holds_done)
            begin
                holds_done = hold_grants;
                rx_wait = RX_HOLD_CYCLES;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles, %0d results owed",
                         idle_cycles, owed_q.size());
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_req(input logic [2:0] act, input logic [9:0] node,
                           input logic [31:0] doff, input logic [31:0] nbytes);
        req_t r;
        r.act = act;
        r.node = node;
        r.doff = doff;
        r.nbytes = nbytes;
        pending_q.push_back(r);
    endtask

    function automatic req_t random_req();
        req_t r;
        int   pick;
        int   v;
        pick = $urandom_range(0, 99);
        r.doff = $urandom();
        r.nbytes = $urandom();
        r.node = 10'($urandom_range(0, MAX_NODES - 1));
        if ($urandom_range(0, 19) == 0)
            r.node = 10'($urandom_range(MAX_NODES, 1023));
        if (pick < 8)
        begin
            r.act = 3'($urandom());
            r.node = 10'($urandom());
        end
        else if (pick < 30)
            r.act = dbt_pkg::ACT_NODE;
        else if (pick < 50)
            r.act = dbt_pkg::ACT_SIZE;
        else if (pick < 76)
        begin
            r.act = dbt_pkg::ACT_DATA;
            v = $urandom_range(0, 9);
            case (v)
                0: r.doff = 32'd0;
                1: r.doff = p_fmax - 32'd1;
                2: r.doff = p_fmax;
                3: r.doff = $urandom();
                default: r.doff = $urandom_range(0, p_fmax - 1);
            endcase
            v = $urandom_range(0, 9);
            case (v)
                0: r.nbytes = 32'd0;
                1: r.nbytes = 32'hFFFF_FFFF;
                2: r.nbytes = $urandom();
                3, 4, 5, 6: r.nbytes = $urandom_range(1, 64);
                default: r.nbytes = $urandom_range(1, 2 * p_fmax);
            endcase
        end
        else if (pick < 84)
            r.act = dbt_pkg::ACT_ALL;
        else
            r.act = dbt_pkg::ACT_SYNC;
        return r;
    endfunction

    task automatic queue_random(input int n);
        repeat (n)
            pending_q.push_back(random_req());
    endtask

    task automatic write_reg(input logic [dbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[dbt_pkg::CFG_W-1:0];
        case (idx)
            dbt_pkg::CFG_PERSIST:   p_persist = val & 32'h1;
            dbt_pkg::CFG_IMG_BLKS:  p_img = val & 32'hFF;
            dbt_pkg::CFG_NODE_BASE: p_base = val & 32'hF_FFFF;
            dbt_pkg::CFG_STRIDE:    p_stride = val & 32'h1F_FFFF;
            dbt_pkg::CFG_DATA_OFS:  p_data_ofs = val & 32'hF_FFFF;
            dbt_pkg::CFG_SIZE_OFS:  p_size_ofs = val & 32'hF_FFFF;
            dbt_pkg::CFG_FILE_MAX:  p_fmax = val & 32'h1F_FFFF;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [31:0] persist, input logic [31:0] img,
                                input logic [31:0] base, input logic [31:0] stride,
                                input logic [31:0] dofs, input logic [31:0] sofs,
                                input logic [31:0] fmax);
        write_reg(dbt_pkg::CFG_PERSIST, persist);
        write_reg(dbt_pkg::CFG_IMG_BLKS, img);
        write_reg(dbt_pkg::CFG_NODE_BASE, base);
        write_reg(dbt_pkg::CFG_STRIDE, stride);
        write_reg(dbt_pkg::CFG_DATA_OFS, dofs);
        write_reg(dbt_pkg::CFG_SIZE_OFS, sofs);
        write_reg(dbt_pkg::CFG_FILE_MAX, fmax);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_q.size() != 0 || in_valid || owed_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        add_req(dbt_pkg::ACT_SYNC, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_NODE, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SIZE, 10'd63, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_DATA, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_DATA, 10'd0, 32'd512, 32'd10);
        add_req(dbt_pkg::ACT_DATA, 10'd0, 32'd511, 32'hFFFF_FFFF);
        add_req(dbt_pkg::ACT_DATA, 10'd1, 32'd0, 32'hFFFF_FFFF);
        add_req(dbt_pkg::ACT_NODE, 10'd64, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SIZE, 10'd1023, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_DATA, 10'd1023, 32'd0, 32'd1);
        add_req(dbt_pkg::ACT_SYNC + 3'd1, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(dbt_pkg::ACT_SYNC + 3'd2, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(dbt_pkg::ACT_SYNC + 3'd3, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(dbt_pkg::ACT_ALL, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SYNC, 10'd0, 32'd0, 32'd0);
        wait_idle();

        apply_config(32'd1, 32'd64, 32'd0, 32'd512, 32'd0, 32'd508, 32'd512);
        add_req(dbt_pkg::ACT_SYNC, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SYNC, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SIZE, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SIZE, 10'd62, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_NODE, 10'd63, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SYNC, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_ALL, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SYNC, 10'd0, 32'd0, 32'd0);
        wait_idle();

        apply_config(32'd1, 32'd10, 32'd0, 32'd512, 32'd0, 32'd508, 32'd512);
        add_req(dbt_pkg::ACT_NODE, 10'd40, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SYNC, 10'd0, 32'd0, 32'd0);
        add_req(dbt_pkg::ACT_SYNC, 10'd0, 32'd0, 32'd0);
        wait_idle();

        apply_config(32'd1, 32'd64, 32'd4, 32'd1024, 32'd0, 32'd0, 32'd512);
        queue_random(45);
        wait_idle();

        apply_config(32'd1, 32'd255, 32'd0, 32'd64, 32'd32, 32'd8, 32'd256);
        queue_random(45);
        wait_idle();

        apply_config(32'd0, 32'd40, 32'd1000, 32'd300, 32'd100, 32'd1023, 32'd2000);
        queue_random(45);
        wait_idle();

        apply_config(32'd1, 32'd0, 32'd1048575, 32'd1048576, 32'd1048575, 32'd1048575,
                     32'd1048576);
        queue_random(45);
        wait_idle();

        apply_config(32'd1, 32'd20, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1);
        queue_random(45);
        wait_idle();

        // Stall the receiver long enough for the block to back up onto its input.
        apply_config(32'd1, 32'd64, 32'd100, 32'd2000, 32'd50, 32'd10, 32'd4096);
        hold_grants++;
        queue_random(45);
        wait_idle();

        no_idle = 1'b1;
        apply_config(32'd1, 32'd33, 32'd16, 32'd700, 32'd0, 32'd200, 32'd1048576);
        queue_random(45);
        wait_idle();
        no_idle = 1'b0;

        repeat (3)
        begin
            apply_config($urandom_range(0, 3) != 0,
                         ($urandom_range(0, 7) == 0) ? $urandom_range(65, 255)
                                                     : $urandom_range(0, 64),
                         $urandom_range(0, 8192), $urandom_range(1, 4096),
                         $urandom_range(0, 2048), $urandom_range(0, 2048),
                         $urandom_range(1, 4096));
            queue_random(45);
            wait_idle();
        end

        $display("Covered %0d items over 13 register settings: %0d results, %0d block writes,",
                 items_sent, results_seen, writes_seen);
        $display("%0d rejected requests, %0d oversize syncs, %0d mismatches",
                 rejects_seen, oversize_seen, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
